// File: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helper for the percent decoder
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PERCENT,
      PHASE_DIGIT
   } phase_type;

   // one decoded group of up to three output bytes
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data2;
      logic [7:0] data1;
      logic [7:0] data0;
      logic       last;
   } cmd_type;

   // returns {is_hex, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// Takes raw bytes, tracks the escape phase and forms output groups
// ----------------------------------------------------------------------------
module upd_front
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       fire;
   logic [4:0] hi_hex, lo_hex;
   logic [7:0] plus_conv;

   assign req_tready = cmd_ready;
   assign fire       = req_tvalid & cmd_ready;
   assign hi_hex     = hex_decode(held_ff);
   assign lo_hex     = hex_decode(req_tdata);
   assign plus_conv  = (req_tdata == CH_PLUS) ? CH_SPACE : req_tdata;

   // next state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      if (fire) begin
         unique case (phase_ff)
            PHASE_PERCENT: begin
               phase_in = req_tlast ? PHASE_IDLE : PHASE_DIGIT;
               held_in  = req_tdata;
            end
            PHASE_DIGIT: begin
               phase_in = PHASE_IDLE;
            end
            default: begin
               phase_in = (req_tdata == CH_PERCENT && !req_tlast) ? PHASE_PERCENT
                                                                   : PHASE_IDLE;
            end
         endcase
         if (req_tlast) begin
            phase_in = PHASE_IDLE;
            held_in  = 8'h00;
         end
      end
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.last  = req_tlast;
      unique case (phase_ff)
         PHASE_PERCENT: begin
            if (req_tlast) begin
               cmd.count = CNT_TWO;
               cmd.data0 = CH_PERCENT;
               cmd.data1 = plus_conv;
            end
         end
         PHASE_DIGIT: begin
            if (hi_hex[4] && lo_hex[4]) begin
               cmd.count = CNT_ONE;
               cmd.data0 = {hi_hex[3:0], lo_hex[3:0]};
            end else begin
               cmd.count = CNT_THREE;
               cmd.data0 = CH_PERCENT;
               cmd.data1 = held_ff;
               cmd.data2 = req_tdata;
            end
         end
         default: begin
            if (req_tdata == CH_PERCENT) begin
               if (req_tlast) begin
                  cmd.count = CNT_ONE;
                  cmd.data0 = CH_PERCENT;
               end
            end else begin
               cmd.count = CNT_ONE;
               cmd.data0 = plus_conv;
            end
         end
      endcase
      cmd_valid = fire && (cmd.count != CNT_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

// File: hw/rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// Two-entry queue of output groups between front and back
// ----------------------------------------------------------------------------
module upd_queue
   import upd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    head_valid,
   input  logic    pop,
   output cmd_type head_cmd
);

   cmd_type    entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'(QUEUE_DEPTH);
   assign head_valid = count_ff != 2'd0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// Emits the bytes of each queued group one per cycle into the output register while it is free
// ----------------------------------------------------------------------------
module upd_back
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head_cmd,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free, emit, is_final;
   logic [7:0] sel_data;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign emit     = head_valid && out_free;
   assign is_final = idx_ff == (head_cmd.count - 2'd1);
   assign pop      = emit && is_final;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_data = head_cmd.data0;
         2'd1:    sel_data = head_cmd.data1;
         default: sel_data = head_cmd.data2;
      endcase
   end

   always_comb begin
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         idx_in        = is_final ? 2'd0 : idx_ff + 2'd1;
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = sel_data;
         rsp_last_in   = head_cmd.last && is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= 2'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming percent decoder for encoded URI bytes
// ----------------------------------------------------------------------------
// req channel: one raw byte per request, tlast on the final byte of a string
// rsp channel: decoded bytes, tlast on the final decoded byte of a string
// '+' gives a space, '%' with two hex digits gives one byte, a bad escape
// gives its three bytes raw, an escape cut by the end of string gives the
// '%' raw followed by normal handling of any remaining byte
// a request's first result is written into the group queue when it is
// accepted, then moves into the output register once that register is free
// throughput: one request per cycle while the group queue has room; a bad
// escape gives three output bytes and an escape cut after one byte gives
// two, drained by the single output register one byte per cycle while free
// the front stalls only when the two-entry group queue is full
// reset clears the escape state, the queue and the output register
// while rsp_tready is low the result holds and the queue fills, then
// req_tready drops
// ----------------------------------------------------------------------------
module url_percent_decoder
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   logic    head_valid, pop;
   cmd_type head_cmd;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_cmd   (cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .head_cmd   (head_cmd)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> cmd_valid)
      else $error("end of string produced no result group");

   a_group_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (cmd.count != CNT_NONE))
      else $error("empty result group pushed");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && rsp_tvalid == 1'b0) || (head_valid && rsp_tready))
      else $error("group popped without emitting");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_cmd.count != CNT_NONE))
      else $error("queue head holds an empty group");
`endif

endmodule

// File: test/url_percent_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_checker
// Watches both stream channels of the decoder, predicts the decoded bytes
// of every accepted request and compares them in order with the results
// ----------------------------------------------------------------------------
module url_percent_decoder_checker
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } decoded_byte_type;

   decoded_byte_type decoded_expected[$];
   phase_type        escape_state;
   logic [7:0]       first_digit;

   // {is_hex, nibble}
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return {1'b1, c[3:0]};
      end
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         return {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return 5'd0;
   endfunction

   task automatic decode_request(input logic [7:0] b, input logic last);
      logic [7:0]       outs [3];
      int               n;
      logic [4:0]       hi;
      logic [4:0]       lo;
      decoded_byte_type item;
      n  = 0;
      hi = nibble_of(first_digit);
      lo = nibble_of(b);
      case (escape_state)
         PHASE_PERCENT: begin
            if (last) begin
               outs[0] = CH_PERCENT;
               outs[1] = (b == CH_PLUS) ? CH_SPACE : b;
               n = 2;
            end else begin
               first_digit  = b;
               escape_state = PHASE_DIGIT;
            end
         end
         PHASE_DIGIT: begin
            if (hi[4] && lo[4]) begin
               outs[0] = {hi[3:0], lo[3:0]};
               n = 1;
            end else begin
               outs[0] = CH_PERCENT;
               outs[1] = first_digit;
               outs[2] = b;
               n = 3;
            end
            escape_state = PHASE_IDLE;
         end
         default: begin
            escape_state = PHASE_IDLE;
            if (b == CH_PERCENT) begin
               if (last) begin
                  outs[0] = CH_PERCENT;
                  n = 1;
               end else begin
                  escape_state = PHASE_PERCENT;
               end
            end else if (b == CH_PLUS) begin
               outs[0] = CH_SPACE;
               n = 1;
            end else begin
               outs[0] = b;
               n = 1;
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         item.value = outs[i];
         item.last  = last && (i == n - 1);
         decoded_expected.push_back(item);
      end
      if (last) begin
         escape_state = PHASE_IDLE;
         first_digit  = 8'h00;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         decoded_expected.delete();
         escape_state = PHASE_IDLE;
         first_digit  = 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_request(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_expected.size() == 0) begin
               $error("unexpected result: out_byte %h out_last %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = decoded_expected.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("out_byte mismatch: expected %h, actual %h", want.value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("out_last mismatch: expected %b, actual %b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      pending_count = decoded_expected.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the percent decoder: directed strings for plus signs, good,
// bad and cut escapes, then random encoded strings with random stalls on
// both channels and one long result hold-off; checking is in the checker
// ----------------------------------------------------------------------------
module tb;
   import upd_pkg::*;

   localparam int RANDOM_ITEMS = 420;
   localparam int HOLD_CYCLES  = 300;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;
   int         fail_count;
   int         pending_count;

   int sent_count  = 0;
   bit quiet       = 1'b0;
   bit sender_gaps = 1'b1;
   bit hold_now    = 1'b0;
   bit hold_done   = 1'b0;

   always #4 clock = ~clock;

   url_percent_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   url_percent_decoder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) begin
         return 8'(8'h30 + v);
      end
      return $urandom_range(0, 1) ? 8'(8'h61 + v - 10) : 8'(8'h41 + v - 10);
   endfunction

   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 5))
         0:       return CH_PLUS;
         1:       return CH_PERCENT;
         2:       return hex_char();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   task automatic send_random_string();
      int         tokens;
      int         kind;
      bit         fin;
      logic [7:0] b1;
      logic [7:0] b2;
      tokens      = $urandom_range(1, 12);
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < tokens; k++) begin
         kind = $urandom_range(0, 99);
         fin  = (k == tokens - 1);
         if (kind < 30) begin
            send_byte(CH_PERCENT, 1'b0);
            send_byte(hex_char(), 1'b0);
            send_byte(hex_char(), fin);
         end else if (kind < 42) begin
            // bad escape
            b1 = any_byte();
            b2 = any_byte();
            if (is_hex(b1) && is_hex(b2)) begin
               b2 = $urandom_range(0, 1) ? CH_PLUS : 8'($urandom_range(8'h67, 8'hFF));
            end
            send_byte(CH_PERCENT, 1'b0);
            send_byte(b1, 1'b0);
            send_byte(b2, fin);
         end else if (kind < 52) begin
            send_byte(CH_PLUS, fin);
         end else if (kind < 58 && fin) begin
            // escape cut by the end of the string
            if ($urandom_range(0, 1)) begin
               send_byte(CH_PERCENT, 1'b1);
            end else begin
               send_byte(CH_PERCENT, 1'b0);
               send_byte(any_byte(), 1'b1);
            end
         end else begin
            send_byte(8'($urandom_range(0, 255)), fin);
         end
      end
   endtask

   // result side: random stalls, one long hold-off
   initial begin
      bit rsp_stalls;
      rsp_stalls = 1'b1;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_now && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && rsp_stalls && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) begin
            rsp_stalls = !rsp_stalls;
         end
      end
   end

   initial begin
      int random_target;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_string("a+b");
      send_string("%41");
      send_string("%fF");
      send_string("%zq");
      send_string("%+1x");
      send_string("%%");
      send_string("%+");
      send_string("%");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      random_target = sent_count + RANDOM_ITEMS;
      while (sent_count < random_target) begin
         if (!hold_now && sent_count > 150) begin
            hold_now = 1'b1;
         end
         if (sent_count > random_target - 60) begin
            quiet = 1'b1;
         end
         send_random_string();
      end
      req_tvalid <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("url_percent_decoder verification clean");
      end else begin
         $display("url_percent_decoder verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("url_percent_decoder verification failed");
      $finish;
   end

endmodule

// File: url_percent_decoder.f
hw/rtl/upd_pkg.sv
hw/rtl/upd_front.sv
hw/rtl/upd_queue.sv
hw/rtl/upd_back.sv
hw/rtl/url_percent_decoder.sv
test/url_percent_decoder_checker.sv
test/tb.sv
